### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/u16u8_pkg.sv
// shared types, constants and byte encoding functions for the utf-16 to utf-8 core
// no dependencies
package u16u8_pkg;

  localparam int CpW = 21;

  localparam logic [5:0]     HiTag     = 6'b110110;
  localparam logic [5:0]     LoTag     = 6'b110111;
  localparam logic [CpW-1:0] SuppBase  = 21'h10000;
  localparam logic [CpW-1:0] HiFirst   = 21'h0D800;
  localparam logic [CpW-1:0] LimitOne  = 21'h00080;
  localparam logic [CpW-1:0] LimitTwo  = 21'h00800;
  localparam logic [7:0]     LeadTwo   = 8'hC0;
  localparam logic [7:0]     LeadThree = 8'hE0;
  localparam logic [7:0]     LeadFour  = 8'hF0;
  localparam logic [7:0]     ContMark  = 8'h80;

  // byte count minus one
  typedef enum logic [1:0] {
    NB_ONE   = 2'd0,
    NB_TWO   = 2'd1,
    NB_THREE = 2'd2,
    NB_FOUR  = 2'd3
  } nbytes_t;

  // one code point waiting to be serialized
  typedef struct packed {
    logic [CpW-1:0] cp;
    nbytes_t        nb;
    logic           last;
    logic           eot;
  } job_t;

  typedef struct packed {
    logic holding;
    logic pending;
  } front_status_t;

  function automatic job_t make_job(logic [CpW-1:0] cp, logic last, logic eot);
    job_t j;
    j.cp   = cp;
    j.last = last;
    j.eot  = eot;
    if (cp < LimitOne) begin
      j.nb = NB_ONE;
    end else if (cp < LimitTwo) begin
      j.nb = NB_TWO;
    end else if (cp < SuppBase) begin
      j.nb = NB_THREE;
    end else begin
      j.nb = NB_FOUR;
    end
    return j;
  endfunction

  function automatic logic [7:0] cont_byte(logic [5:0] bits);
    return ContMark | {2'b00, bits};
  endfunction

  function automatic logic [7:0] utf8_byte(logic [CpW-1:0] cp, nbytes_t nb, logic [1:0] idx);
    logic [7:0] b;
    b = cont_byte(cp[5:0]);
    unique case (nb)
      NB_ONE: b = {1'b0, cp[6:0]};
      NB_TWO: begin
        if (idx == 2'd0) b = LeadTwo | {3'b000, cp[10:6]};
        else             b = cont_byte(cp[5:0]);
      end
      NB_THREE: begin
        case (idx)
          2'd0:    b = LeadThree | {4'b0000, cp[15:12]};
          2'd1:    b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
      NB_FOUR: begin
        case (idx)
          2'd0:    b = LeadFour | {5'b00000, cp[20:18]};
          2'd1:    b = cont_byte(cp[17:12]);
          2'd2:    b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
      default: b = cont_byte(cp[5:0]);
    endcase
    return b;
  endfunction

endpackage

### hdl/u16u8_front.sv
// front end: accepts code units, pairs surrogates, pushes code point jobs
// depends on u16u8_pkg
module u16u8_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [15:0]               in_code_unit,
  input  logic                      in_final_unit,
  input  logic                      q_full,
  output logic                      push_valid,
  output u16u8_pkg::job_t           push_job,
  output u16u8_pkg::front_status_t  status
);
  import u16u8_pkg::*;

  logic       held_r, held_nxt;
  logic [9:0] hb_r, hb_nxt;
  logic       pend_r, pend_nxt;
  job_t       pend_job_r, pend_job_nxt;
  logic       accept, is_hi, is_lo;
  logic [CpW-1:0] pair_cp, lone_cp, unit_cp;

  assign in_stall = pend_r || q_full;
  assign accept   = in_valid && !in_stall;
  assign is_hi    = in_code_unit[15:10] == HiTag;
  assign is_lo    = in_code_unit[15:10] == LoTag;
  assign pair_cp  = SuppBase + {1'b0, hb_r, in_code_unit[9:0]};
  assign lone_cp  = HiFirst | {11'd0, hb_r};
  assign unit_cp  = {5'd0, in_code_unit};

  always_comb begin
    held_nxt     = held_r;
    hb_nxt       = hb_r;
    pend_nxt     = pend_r;
    pend_job_nxt = pend_job_r;
    push_valid   = 1'b0;
    push_job     = pend_job_r;
    if (pend_r) begin
      if (!q_full) begin
        push_valid = 1'b1;
        pend_nxt   = 1'b0;
      end
    end else if (accept) begin
      if (held_r) begin
        held_nxt   = 1'b0;
        push_valid = 1'b1;
        if (is_lo) begin
          push_job = make_job(pair_cp, 1'b1, in_final_unit);
        end else if (is_hi && !in_final_unit) begin
          // flushed surrogate ends the run, new one is held
          push_job = make_job(lone_cp, 1'b1, 1'b0);
          held_nxt = 1'b1;
          hb_nxt   = in_code_unit[9:0];
        end else begin
          push_job     = make_job(lone_cp, 1'b0, 1'b0);
          pend_nxt     = 1'b1;
          pend_job_nxt = make_job(unit_cp, 1'b1, in_final_unit);
        end
      end else if (is_hi && !in_final_unit) begin
        held_nxt = 1'b1;
        hb_nxt   = in_code_unit[9:0];
      end else begin
        push_valid = 1'b1;
        push_job   = make_job(unit_cp, 1'b1, in_final_unit);
      end
    end
  end

  assign status.holding = held_r;
  assign status.pending = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hb_r       <= hb_nxt;
    pend_job_r <= pend_job_nxt;
  end

endmodule

### hdl/u16u8_fifo.sv
// small job queue between front and back
// depends on u16u8_pkg
module u16u8_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output u16u8_pkg::job_t head,
  output logic            empty
);
  import u16u8_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

endmodule

### hdl/u16u8_back.sv
// back end: serializes one code point job into utf-8 bytes, one per cycle while out_stall is low
// depends on u16u8_pkg
module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  u16u8_pkg::job_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run,
  output logic            out_end_of_text
);
  import u16u8_pkg::*;

  logic       busy_r, busy_nxt;
  job_t       cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ol_r, ol_nxt;
  logic       oe_r, oe_nxt;
  logic       load, fin_byte;

  assign load     = !ov_r || !out_stall;
  assign fin_byte = idx_r == cur_r.nb;

  always_comb begin
    busy_nxt = busy_r;
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    oe_nxt   = oe_r;
    q_pop    = 1'b0;
    if (load) begin
      ov_nxt = busy_r;
      if (busy_r) begin
        ob_nxt = utf8_byte(cur_r.cp, cur_r.nb, idx_r);
        ol_nxt = fin_byte && cur_r.last;
        oe_nxt = fin_byte && cur_r.eot;
        if (fin_byte) busy_nxt = 1'b0;
        else          idx_nxt  = idx_r + 2'd1;
      end
    end
    if (!q_empty && (!busy_r || (load && fin_byte))) begin
      q_pop    = 1'b1;
      cur_nxt  = q_head;
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_last_of_run = ol_r;
  assign out_end_of_text = oe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
    oe_r  <= oe_nxt;
  end

endmodule

### hdl/utf16_to_utf8_stream_core.sv
// top level of the utf-16 to utf-8 stream transcoder
// depends on u16u8_pkg, u16u8_front, u16u8_fifo, u16u8_back, assert_macros.svh
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    in_code_unit[15:0], in_final_unit
//  out      out  out_valid/out_stall  out_byte[7:0], out_last_of_run, out_end_of_text
//
// the back end sends one byte per cycle while out_stall is low; a word yields
// 0 bytes for a held high surrogate, 1 to 4 otherwise, up to 6 when a
// held surrogate is flushed ahead of a new word
// the front takes a word per cycle unless the queue is full or a job is pending;
// the new word waits as a pending job when a flushed surrogate also needs a slot
// synchronous active-low reset empties the queue and drops any held surrogate
// out_stall holds the output register; the queue lets words keep coming until full
`include "assert_macros.svh"

module utf16_to_utf8_stream_core #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        in_final_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_end_of_text
);
  import u16u8_pkg::*;

  // front to queue
  logic          push_valid;
  job_t          push_job;
  logic          q_full;
  front_status_t fstat;

  // queue to back
  logic q_pop, q_empty;
  job_t q_head;

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_unit (in_code_unit),
    .in_final_unit(in_final_unit),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .push_job     (push_job),
    .status       (fstat)
  );

  u16u8_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push_valid),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run),
    .out_end_of_text(out_end_of_text)
  );

  // the front never pushes into a full queue
  `ASSERT_IMPL(a_push_not_full, clk, rst_n, push_valid, !q_full)
  // the back never pops an empty queue
  `ASSERT_IMPL(a_pop_not_empty, clk, rst_n, q_pop, !q_empty)
  // a final word never leaves a surrogate held
  `ASSERT_NEXT(a_final_clears_hold, clk, rst_n,
               in_valid && !in_stall && in_final_unit, !fstat.holding)
  // end of text only marks the end of a run
  `ASSERT_IMPL(a_end_is_last, clk, rst_n, out_valid && out_end_of_text, out_last_of_run)
  // a second job waiting in the front keeps the input stalled
  `ASSERT_IMPL(a_pend_stalls, clk, rst_n, fstat.pending, in_stall)

endmodule
